>>> src/bfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfc_pkg
// shared constants for the box frustum cull test
// ----------------------------------------------------------------------------
package bfc_pkg;

    localparam int COORD_BITS_DEF = 16;   // coordinate width, signed Q11.4 by default
    localparam int COEF_BITS      = 16;   // plane coefficient width, signed Q1.14
    localparam int COEF_FRAC      = 14;   // fraction bits of a plane coefficient
    localparam int PLANE_COUNT    = 6;
    localparam int PLANE_W        = 64;   // packed plane register width
    localparam int CFG_IDX_W      = 3;
    localparam int CORNER_COUNT   = 8;
    localparam int D_LSB          = 48;   // plane offset field starts here
    localparam int D_AVAIL        = PLANE_W - D_LSB;
    localparam int PIPE_DEPTH     = 5;    // request to result strobe

    typedef logic [CORNER_COUNT-1:0] t_corner_mask;

endpackage

>>> src/bfc_plane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfc_plane
// pipelined test of the eight box corners against one plane
// ----------------------------------------------------------------------------
module bfc_plane
    import bfc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic [PLANE_W-1:0]           i_plane,
    input  logic signed [COORD_BITS-1:0] i_cx,
    input  logic signed [COORD_BITS-1:0] i_cy,
    input  logic signed [COORD_BITS-1:0] i_cz,
    input  logic [COORD_BITS-2:0]        i_hx,
    input  logic [COORD_BITS-2:0]        i_hy,
    input  logic [COORD_BITS-2:0]        i_hz,
    output t_corner_mask                 o_inside
);

    localparam int PW = COORD_BITS + COEF_BITS;   // one product
    localparam int SW = COORD_BITS + 19;          // full plane sum

    logic signed [COEF_BITS-1:0]  coef_a, coef_b, coef_c;
    logic signed [COORD_BITS-1:0] d_off;

    assign coef_a = i_plane[COEF_BITS-1:0];
    assign coef_b = i_plane[2*COEF_BITS-1:COEF_BITS];
    assign coef_c = i_plane[3*COEF_BITS-1:2*COEF_BITS];

    // offset field is cut off by the top of the register for wide coordinates
    genvar gi;
    generate
        for (gi = 0; gi < COORD_BITS; gi++) begin : g_doff
            if (gi < D_AVAIL) begin : g_bit
                assign d_off[gi] = i_plane[D_LSB+gi];
            end else begin : g_zero
                assign d_off[gi] = 1'b0;
            end
        end
    endgenerate

    // stage 1: products for centre and half extents
    logic signed [PW-1:0] r_pcx, r_pcy, r_pcz, r_phx, r_phy, r_phz;
    logic signed [COORD_BITS-1:0] r_d;

    always_ff @(posedge i_clk) begin
        r_pcx <= coef_a * i_cx;
        r_pcy <= coef_b * i_cy;
        r_pcz <= coef_c * i_cz;
        r_phx <= coef_a * $signed({1'b0, i_hx});
        r_phy <= coef_b * $signed({1'b0, i_hy});
        r_phz <= coef_c * $signed({1'b0, i_hz});
        r_d   <= d_off;
    end

    // stage 2: centre sum and the eight signed half-extent combinations
    logic signed [SW-1:0] ex_cx, ex_cy, ex_cz, ex_hx, ex_hy, ex_hz, ex_d;
    logic signed [SW-1:0] n_base;
    logic signed [SW-1:0] n_comb [CORNER_COUNT];
    logic signed [SW-1:0] r_base;
    logic signed [SW-1:0] r_comb [CORNER_COUNT];

    assign ex_cx = {{(SW-PW){r_pcx[PW-1]}}, r_pcx};
    assign ex_cy = {{(SW-PW){r_pcy[PW-1]}}, r_pcy};
    assign ex_cz = {{(SW-PW){r_pcz[PW-1]}}, r_pcz};
    assign ex_hx = {{(SW-PW){r_phx[PW-1]}}, r_phx};
    assign ex_hy = {{(SW-PW){r_phy[PW-1]}}, r_phy};
    assign ex_hz = {{(SW-PW){r_phz[PW-1]}}, r_phz};
    assign ex_d  = {{(SW-COORD_BITS-COEF_FRAC){r_d[COORD_BITS-1]}}, r_d, {COEF_FRAC{1'b0}}};

    assign n_base = ex_cx + ex_cy + ex_cz + ex_d;

    // corner bit 0 picks +x, bit 1 +y, bit 2 +z
    always_comb begin
        for (int k = 0; k < CORNER_COUNT; k++) begin
            n_comb[k] = (k[0] ? ex_hx : -ex_hx)
                      + (k[1] ? ex_hy : -ex_hy)
                      + (k[2] ? ex_hz : -ex_hz);
        end
    end

    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        r_comb <= n_comb;
    end

    // stage 3: sign of each corner sum
    logic signed [SW-1:0] corner_sum [CORNER_COUNT];
    t_corner_mask         n_inside;
    t_corner_mask         r_inside;

    always_comb begin
        for (int k = 0; k < CORNER_COUNT; k++) begin
            corner_sum[k] = r_base + r_comb[k];
            n_inside[k]   = ~corner_sum[k][SW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_inside <= n_inside;
    end

    assign o_inside = r_inside;

endmodule

>>> src/box_frustum_cull_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_frustum_cull_test
// axis-aligned box against six frustum planes
// ----------------------------------------------------------------------------
// Takes one box request per clock: busy never rises, and start may be held
// high for a continuous stream. Each request gives one visible result, marked
// by o_valid for one cycle; the receiver cannot stall, so results must be
// taken as they come. A request passes the input register, the coefficient
// multipliers of each plane, the centre and half-extent sums, the per-corner
// sign test and the result register. A box is visible when one of its eight
// corners is on the non-negative side of all six planes. Planes are to be
// written through the cfg port only while no request is in flight; the block
// does not enforce this. The port never stalls; indexes past the far plane
// are ignored. After reset all planes are zero, so each box reads as visible.
// ----------------------------------------------------------------------------
module box_frustum_cull_test
    import bfc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] i_center_x,
    input  logic signed [COORD_BITS-1:0] i_center_y,
    input  logic signed [COORD_BITS-1:0] i_center_z,
    input  logic [COORD_BITS-2:0]        i_half_x,
    input  logic [COORD_BITS-2:0]        i_half_y,
    input  logic [COORD_BITS-2:0]        i_half_z,
    output logic                         o_valid,
    output logic                         o_visible,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [PLANE_W-1:0]           i_cfg_data
);

    logic [PLANE_W-1:0] r_plane [PLANE_COUNT];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PLANE_COUNT; p++) begin
                r_plane[p] <= '0;
            end
        end else if (i_cfg_valid && o_cfg_ready
                     && (32'(i_cfg_index) < PLANE_COUNT)) begin
            r_plane[i_cfg_index] <= i_cfg_data;
        end
    end

    // input register
    logic signed [COORD_BITS-1:0] r_cx, r_cy, r_cz;
    logic [COORD_BITS-2:0]        r_hx, r_hy, r_hz;

    always_ff @(posedge i_clk) begin
        r_cx <= i_center_x;
        r_cy <= i_center_y;
        r_cz <= i_center_z;
        r_hx <= i_half_x;
        r_hy <= i_half_y;
        r_hz <= i_half_z;
    end

    t_corner_mask plane_inside [PLANE_COUNT];

    genvar gp;
    generate
        for (gp = 0; gp < PLANE_COUNT; gp++) begin : g_plane
            bfc_plane #(
                .COORD_BITS (COORD_BITS)
            ) u_plane (
                .i_clk    (i_clk),
                .i_plane  (r_plane[gp]),
                .i_cx     (r_cx),
                .i_cy     (r_cy),
                .i_cz     (r_cz),
                .i_hx     (r_hx),
                .i_hy     (r_hy),
                .i_hz     (r_hz),
                .o_inside (plane_inside[gp])
            );
        end
    endgenerate

    // a corner counts only if every plane passes it
    t_corner_mask all_inside;
    logic         n_visible;
    logic         r_visible;

    always_comb begin
        all_inside = '1;
        for (int p = 0; p < PLANE_COUNT; p++) begin
            all_inside = all_inside & plane_inside[p];
        end
        n_visible = |all_inside;
    end

    always_ff @(posedge i_clk) begin
        r_visible <= n_visible;
    end

    // request strobe follows the data down the pipe
    logic [PIPE_DEPTH-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], start && !busy};
        end
    end

    assign o_valid   = r_vld[PIPE_DEPTH-1];
    assign o_visible = r_visible;

    a_req_gives_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##5 o_valid)
        else $error("request did not produce a result");

    a_result_has_req : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 5))
        else $error("result without a request");

    a_zero_planes_visible : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(r_plane[0] == '0 && r_plane[1] == '0 && r_plane[2] == '0
                          && r_plane[3] == '0 && r_plane[4] == '0
                          && r_plane[5] == '0, 4)) |-> o_visible)
        else $error("all-zero planes must report visible");

endmodule

>>> dv/box_frustum_cull_test_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_frustum_cull_test_tb
// self-checking bench for the box frustum cull test
// ----------------------------------------------------------------------------
// Loads sets of six planes (zero planes, an axis-aligned cube, random oblique
// planes, extreme coefficients, raw random words) and streams boxes through
// the block with random gaps. A scoreboard predicts the visible flag of each
// request by testing all eight corners against the current planes and
// checks every result strobe against the oldest prediction in order.
// ----------------------------------------------------------------------------
module box_frustum_cull_test_tb;
    import bfc_pkg::*;

    localparam int CB             = COORD_BITS_DEF;
    localparam int COEF_ONE       = 1 << COEF_FRAC;
    localparam int CUBE_EDGE      = 1000;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum logic [CFG_IDX_W-1:0] {
        PLANE_LEFT   = 0,
        PLANE_RIGHT  = 1,
        PLANE_BOTTOM = 2,
        PLANE_TOP    = 3,
        PLANE_NEAR   = 4,
        PLANE_FAR    = 5,
        SLOT_SPARE_A = 6,
        SLOT_SPARE_B = 7
    } t_plane_slot;

    typedef struct {
        logic signed [CB-1:0] cx, cy, cz;
        logic [CB-2:0]        hx, hy, hz;
    } t_box;

    class t_cull_scoreboard;
        logic [PLANE_W-1:0] planes [PLANE_COUNT];
        bit                 visible_q [$];
        int unsigned        errors, boxes, results, visible_count, plane_writes;

        function new();
            foreach (planes[p]) planes[p] = '0;
        endfunction

        function void load_plane(logic [CFG_IDX_W-1:0] idx, logic [PLANE_W-1:0] value);
            plane_writes++;
            // slots past the far plane are dropped by the block
            if (idx < PLANE_COUNT) planes[idx] = value;
        endfunction

        function bit corner_inside(longint x, longint y, longint z);
            longint a, b, c, d, s;
            for (int p = 0; p < PLANE_COUNT; p++) begin
                a = longint'($signed(planes[p][15:0]));
                b = longint'($signed(planes[p][31:16]));
                c = longint'($signed(planes[p][47:32]));
                d = longint'($signed(planes[p][D_LSB +: CB]));
                s = a * x + b * y + c * z + d * longint'(COEF_ONE);
                if (s < 0) return 0;
            end
            return 1;
        endfunction

        function void note_box(t_box bx);
            longint xs [2], ys [2], zs [2];
            bit     hit;
            xs[0] = longint'(bx.cx) - longint'(bx.hx);
            xs[1] = longint'(bx.cx) + longint'(bx.hx);
            ys[0] = longint'(bx.cy) - longint'(bx.hy);
            ys[1] = longint'(bx.cy) + longint'(bx.hy);
            zs[0] = longint'(bx.cz) - longint'(bx.hz);
            zs[1] = longint'(bx.cz) + longint'(bx.hz);
            hit = 0;
            for (int k = 0; k < CORNER_COUNT; k++)
                if (!hit && corner_inside(xs[k & 1], ys[(k >> 1) & 1], zs[(k >> 2) & 1]))
                    hit = 1;
            visible_q.push_back(hit);
            boxes++;
        endfunction

        function void check_result(logic got);
            bit want;
            if (visible_q.size() == 0) begin
                errors++;
                $display("%0t: result with no request waiting, expected none, actual %0b",
                         $time, got);
                return;
            end
            want = visible_q.pop_front();
            results++;
            if (got === 1'b1) visible_count++;
            if (got !== want) begin
                errors++;
                $display("%0t: visible mismatch, expected %0b, actual %0b",
                         $time, want, got);
            end
        endfunction

        function int pending();
            return visible_q.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic signed [CB-1:0] center_x, center_y, center_z;
    logic [CB-2:0]        half_x, half_y, half_z;
    logic                 o_valid;
    logic                 o_visible;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [PLANE_W-1:0]   i_cfg_data;

    t_cull_scoreboard sb;
    bit               gaps_on;
    bit               moved;
    int unsigned      quiet_cycles;

    box_frustum_cull_test #(.COORD_BITS(CB)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_center_x  (center_x),
        .i_center_y  (center_y),
        .i_center_z  (center_z),
        .i_half_x    (half_x),
        .i_half_y    (half_y),
        .i_half_z    (half_z),
        .o_valid     (o_valid),
        .o_visible   (o_visible),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // request, plane write and result monitor plus the stall watchdog
    always @(posedge i_clk) begin
        moved = 0;
        if (i_rst_n) begin
            if (o_valid) begin
                sb.check_result(o_visible);
                moved = 1;
            end
            if (start && !busy) begin
                sb.note_box('{center_x, center_y, center_z, half_x, half_y, half_z});
                moved = 1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                sb.load_plane(i_cfg_index, i_cfg_data);
                moved = 1;
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d results outstanding",
                     $time, sb.pending());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int sym(int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    function automatic t_box mk_box(int cx, int cy, int cz, int hx, int hy, int hz);
        t_box bx;
        bx.cx = CB'(cx);
        bx.cy = CB'(cy);
        bx.cz = CB'(cz);
        bx.hx = (CB-1)'(hx);
        bx.hy = (CB-1)'(hy);
        bx.hz = (CB-1)'(hz);
        return bx;
    endfunction

    function automatic t_box random_box(int span, int reach);
        t_box bx;
        int   pick;
        pick  = $urandom_range(99);
        bx.cx = CB'($urandom);
        bx.cy = CB'($urandom);
        bx.cz = CB'($urandom);
        bx.hx = (CB-1)'($urandom);
        bx.hy = (CB-1)'($urandom);
        bx.hz = (CB-1)'($urandom);
        if (pick >= 15) begin
            bx = mk_box(sym(span), sym(span), sym(span), $urandom_range(reach),
                        $urandom_range(reach), $urandom_range(reach));
            // points
            if (pick < 27) begin
                bx.hx = '0;
                bx.hy = '0;
                bx.hz = '0;
            end
            if (pick >= 95) bx.hx = '1;
        end
        return bx;
    endfunction

    function automatic logic [PLANE_W-1:0] pack_plane(int a, int b, int c, int d);
        return {16'(d), 16'(c), 16'(b), 16'(a)};
    endfunction

    task automatic send_box(t_box bx);
        @(negedge i_clk);
        while (gaps_on && $urandom_range(99) < 27) begin
            start    = 1'b0;
            center_x = CB'($urandom);
            center_y = CB'($urandom);
            center_z = CB'($urandom);
            half_x   = (CB-1)'($urandom);
            half_y   = (CB-1)'($urandom);
            half_z   = (CB-1)'($urandom);
            @(negedge i_clk);
        end
        start    = 1'b1;
        center_x = bx.cx;
        center_y = bx.cy;
        center_z = bx.cz;
        half_x   = bx.hx;
        half_y   = bx.hy;
        half_z   = bx.hz;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic wait_until_clear();
        @(negedge i_clk);
        start = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic settle();
        wait_until_clear();
        repeat (PIPE_DEPTH + 2) @(posedge i_clk);
    endtask

    task automatic write_plane(t_plane_slot idx, logic [PLANE_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // axis-aligned cube: each plane keeps one face's inner half-space
    task automatic load_cube(int lo_x, int hi_x, int lo_y, int hi_y, int lo_z, int hi_z);
        settle();
        write_plane(PLANE_LEFT,   pack_plane(COEF_ONE, 0, 0, -lo_x));
        write_plane(PLANE_RIGHT,  pack_plane(-COEF_ONE, 0, 0, hi_x));
        write_plane(PLANE_BOTTOM, pack_plane(0, COEF_ONE, 0, -lo_y));
        write_plane(PLANE_TOP,    pack_plane(0, -COEF_ONE, 0, hi_y));
        write_plane(PLANE_NEAR,   pack_plane(0, 0, COEF_ONE, -lo_z));
        write_plane(PLANE_FAR,    pack_plane(0, 0, -COEF_ONE, hi_z));
    endtask

    task automatic run_random(int count, int span, int reach);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(199) == 0) wait_until_clear();
            send_box(random_box(span, reach));
        end
    endtask

    initial begin
        sb          = new();
        gaps_on     = 1'b1;
        start       = 1'b0;
        center_x    = '0;
        center_y    = '0;
        center_z    = '0;
        half_x      = '0;
        half_y      = '0;
        half_z      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_rst_n     = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // planes still zero after reset, so every box should come back visible
        send_box(mk_box(0, 0, 0, 0, 0, 0));
        send_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
        send_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
        send_box(mk_box(-32768, 32767, -1, 0, 0, 0));
        send_box(mk_box(32767, -32768, 0, 1, 32767, 0));

        load_cube(-CUBE_EDGE, CUBE_EDGE, -CUBE_EDGE, CUBE_EDGE, -CUBE_EDGE, CUBE_EDGE);
        // writes to the spare slots must leave the cube untouched
        write_plane(SLOT_SPARE_A, {$urandom, $urandom});
        write_plane(SLOT_SPARE_B, '1);
        send_box(mk_box(0, 0, 0, 0, 0, 0));
        send_box(mk_box(CUBE_EDGE, 0, 0, 0, 0, 0));           // on a face, counts as inside
        send_box(mk_box(CUBE_EDGE + 1, 0, 0, 0, 0, 0));
        send_box(mk_box(-CUBE_EDGE - 1, 0, 0, 0, 0, 0));
        send_box(mk_box(0, 0, CUBE_EDGE + 1, 0, 0, 0));
        send_box(mk_box(2 * CUBE_EDGE, 0, 0, CUBE_EDGE - 1, 0, 0));
        send_box(mk_box(2 * CUBE_EDGE, 0, 0, CUBE_EDGE, 0, 0));
        // box enclosing the whole cube has no corner inside
        send_box(mk_box(0, 0, 0, 32767, 32767, 32767));
        send_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
        send_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
        send_box(mk_box(-32768, -32768, -32768, 0, 0, 0));
        send_box(mk_box(32767, 32767, 32767, 0, 0, 0));
        send_box(mk_box(-32768, 32767, 0, 32767, 32767, 0));

        // back-to-back stretch before the random gaps come in
        gaps_on = 1'b0;
        run_random(250, 2 * CUBE_EDGE, CUBE_EDGE / 2);
        gaps_on = 1'b1;

        load_cube(-sym(6000) - 2000, sym(6000) + 8000, -int'($urandom_range(8000)),
                  int'($urandom_range(8000)), -12000, 4000);
        run_random(200, 12000, 2000);

        // oblique planes with the origin region kept inside
        settle();
        for (int p = 0; p < PLANE_COUNT; p++)
            write_plane(t_plane_slot'(p), pack_plane(sym(COEF_ONE), sym(COEF_ONE),
                        sym(COEF_ONE), $urandom_range(16000)));
        run_random(250, 8000, 1500);

        // extreme coefficients and offsets
        settle();
        for (int p = 0; p < PLANE_COUNT; p++)
            write_plane(t_plane_slot'(p), '1);
        run_random(100, 20000, 8000);
        settle();
        for (int p = 0; p < PLANE_COUNT; p++)
            write_plane(t_plane_slot'(p), (p % 2 == 0) ? pack_plane(-32768, 32767, -32768, 32767)
                                                      : pack_plane(32767, -32768, 32767, 32767));
        run_random(100, 20000, 8000);

        settle();
        for (int p = 0; p < PLANE_COUNT; p++)
            write_plane(t_plane_slot'(p), {$urandom, $urandom});
        run_random(150, 32767, 32767);

        settle();
        for (int p = 0; p < PLANE_COUNT; p++)
            write_plane(t_plane_slot'(p), '0);
        run_random(150, 32767, 32767);

        settle();
        if (sb.pending() != 0) begin
            sb.errors++;
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
        end
        $display("boxes sent %0d over %0d plane writes incl. spare slots; results %0d",
                 sb.boxes, sb.plane_writes, sb.results);
        $display("reported visible %0d, culled %0d, failures %0d",
                 sb.visible_count, sb.results - sb.visible_count, sb.errors);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
